[sv/bras_pkg.sv]
// bras_pkg: shared constants and types for the bit map range and scan engine
// holds map geometry, field widths, request codes and the sequencer state type
// no dependencies
`default_nettype none

package bras_pkg;

    localparam int MAP_BITS          = 1024;
    localparam int DEF_WORD_BITS     = 8;
    localparam int IDX_W             = 10;
    localparam int LEN_W             = 11;
    localparam int FUNC_W            = 4;

    // request codes
    localparam logic [FUNC_W-1:0] FN_WRITE_BIT  = 4'd0;
    localparam logic [FUNC_W-1:0] FN_WRITE_RUN  = 4'd1;
    localparam logic [FUNC_W-1:0] FN_GUARD_RUN  = 4'd2;
    localparam logic [FUNC_W-1:0] FN_READ       = 4'd3;
    localparam logic [FUNC_W-1:0] FN_NEXT_ONE   = 4'd4;
    localparam logic [FUNC_W-1:0] FN_PREV_ONE   = 4'd5;
    localparam logic [FUNC_W-1:0] FN_NEXT_ZERO  = 4'd6;
    localparam logic [FUNC_W-1:0] FN_PREV_ZERO  = 4'd7;
    localparam logic [FUNC_W-1:0] FN_GUARD_BIT  = 4'd8;
    localparam logic [FUNC_W-1:0] FN_FILL       = 4'd9;

    typedef enum logic {
        S_IDLE,
        S_RUN
    } t_state;

endpackage

`default_nettype wire

[sv/bitmap_range_and_scan_engine.sv]
// bitmap_range_and_scan_engine: bit map and guard map with run writes and scans
// depends on bras_pkg for geometry, request codes and the state type
`default_nettype none

// usage
//   a request is taken at a rising edge with start high and busy low; i_func
//   picks the operation, i_start_index / i_run_length / i_bit_value are its
//   operands. exactly one result per request appears for one cycle with
//   o_done high; the receiver cannot stall it, so it must be taken then.
//   map length is written through i_cfg_we / i_cfg_wdata while no request is
//   in flight; values above the map size act as the map size.
// timing
//   both maps live in word memories with one read and one write port and
//   registered read data. one shared word unit (range mask, merge, popcount,
//   priority find) walks the words, one word per cycle, reads pipelined one
//   word ahead of the write-back. a request touching k words reads them in
//   turn and raises o_done through the result register once the last word
//   is merged; a full-map run, scan or fill walks every map word. scans stop
//   at the first word holding a hit. requests rejected up front (out of range,
//   empty run, unused code) give o_done on the next cycle.
//   busy drops on the same edge that raises o_done, so a new request may be
//   taken during the result cycle.
// reset: synchronous, active low; length becomes 1024 and both maps read as
//   zero through per-word valid flags, so no clearing pass is needed
module bitmap_range_and_scan_engine
    import bras_pkg::*;
#(
    parameter int WORD_BITS = DEF_WORD_BITS
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire logic [FUNC_W-1:0] i_func,
    input  wire logic [IDX_W-1:0]  i_start_index,
    input  wire logic [LEN_W-1:0]  i_run_length,
    input  wire logic              i_bit_value,
    input  wire logic              i_cfg_we,
    input  wire logic [LEN_W-1:0]  i_cfg_wdata,
    output logic                   o_done,
    output logic                   o_status,
    output logic [IDX_W-1:0]       o_found_index,
    output logic                   o_read_bit,
    output logic [LEN_W-1:0]       o_changed_count
);

    localparam int LB    = $clog2(WORD_BITS);
    localparam int NW    = MAP_BITS / WORD_BITS;
    localparam int AW    = IDX_W - LB;
    localparam int END_W = LEN_W + 1;
    localparam int PC_W  = LB + 1;

    // sequencer state
    t_state r_state, n_state;

    // configuration
    logic [LEN_W-1:0] r_len;
    logic [LEN_W-1:0] len_act;

    // request held for the walk
    logic [FUNC_W-1:0] r_func;
    logic              r_val;
    logic [IDX_W-1:0]  r_lo;
    logic [LEN_W-1:0]  r_hix;
    logic [AW-1:0]     r_last;
    logic              r_down;

    // read pipeline
    logic [AW-1:0]     r_rd_addr;
    logic              r_rd_more;
    logic              r_pv;
    logic [AW-1:0]     r_paddr;
    logic              r_plast;
    logic [LEN_W-1:0]  r_cnt;

    // word memories with per-word valid flags
    logic [WORD_BITS-1:0] r_map_mem [NW];
    logic [WORD_BITS-1:0] r_grd_mem [NW];
    logic [NW-1:0]        r_map_ok;
    logic [NW-1:0]        r_grd_ok;
    logic [WORD_BITS-1:0] r_map_q;
    logic [WORD_BITS-1:0] r_grd_q;
    logic                 r_map_vq;
    logic                 r_grd_vq;

    // result registers
    logic              r_done;
    logic              r_status;
    logic [IDX_W-1:0]  r_found;
    logic              r_rbit;
    logic [LEN_W-1:0]  r_chg;

    // decode of the incoming request
    logic              accept;
    logic              d_err;
    logic [IDX_W-1:0]  d_lo;
    logic [LEN_W-1:0]  d_hix;
    logic [AW-1:0]     d_first;
    logic [AW-1:0]     d_last;
    logic              d_down;
    logic [LEN_W-1:0]  idx_ext;
    logic [END_W-1:0]  run_end;
    logic [END_W-1:0]  run_end_m1;
    logic [LEN_W-1:0]  len_m1;

    // shared word unit
    logic                 run_on;
    logic                 rd_en;
    logic                 pv;
    logic [WORD_BITS-1:0] map_w;
    logic [WORD_BITS-1:0] grd_w;
    logic [WORD_BITS-1:0] inr;
    logic [WORD_BITS-1:0] base_w;
    logic [WORD_BITS-1:0] wmask;
    logic [WORD_BITS-1:0] new_word;
    logic [WORD_BITS-1:0] match;
    logic [PC_W-1:0]      pc;
    logic [LB-1:0]        lo_pos;
    logic [LB-1:0]        hi_pos;
    logic                 any_hit;
    logic                 is_search;
    logic                 is_read;
    logic                 is_run;
    logic                 is_wmap;
    logic                 is_wgrd;
    logic                 finish;
    logic                 map_we;
    logic                 grd_we;
    logic [LEN_W-1:0]     cnt_sum;

    // length above the map size acts as the map size
    assign len_act = (r_len > LEN_W'(MAP_BITS)) ? LEN_W'(MAP_BITS) : r_len;

    assign accept     = start && (r_state == S_IDLE);
    assign idx_ext    = {{(LEN_W-IDX_W){1'b0}}, i_start_index};
    assign run_end    = {1'b0, idx_ext} + {1'b0, i_run_length};
    assign run_end_m1 = run_end - END_W'(1);
    assign len_m1     = len_act - LEN_W'(1);

    // operand decode: bounds of the bit range and the words to walk
    always_comb begin
        d_err   = 1'b0;
        d_lo    = i_start_index;
        d_hix   = idx_ext + LEN_W'(1);
        d_first = i_start_index[IDX_W-1:LB];
        d_last  = i_start_index[IDX_W-1:LB];
        d_down  = 1'b0;
        unique case (i_func) inside
            FN_WRITE_BIT, FN_READ, FN_GUARD_BIT: begin
                d_err = (idx_ext >= len_act);
            end
            FN_WRITE_RUN, FN_GUARD_RUN: begin
                d_err  = (i_run_length == '0) || (run_end > {1'b0, len_act});
                d_hix  = run_end[LEN_W-1:0];
                d_last = run_end_m1[IDX_W-1:LB];
            end
            FN_NEXT_ONE, FN_NEXT_ZERO: begin
                d_err  = (idx_ext >= len_act);
                d_hix  = len_act;
                d_last = len_m1[IDX_W-1:LB];
            end
            FN_PREV_ONE, FN_PREV_ZERO: begin
                d_err  = (idx_ext >= len_act);
                d_lo   = '0;
                d_last = '0;
                d_down = 1'b1;
            end
            FN_FILL: begin
                // bits at or above the length are cleared, so every word is written
                d_lo    = '0;
                d_hix   = len_act;
                d_first = '0;
                d_last  = '1;
            end
            default: begin
                d_err = 1'b1;
            end
        endcase
    end

    // request classes
    always_comb begin
        is_search = 1'b0;
        is_read   = 1'b0;
        is_run    = 1'b0;
        is_wmap   = 1'b0;
        is_wgrd   = 1'b0;
        unique case (r_func) inside
            FN_WRITE_BIT, FN_FILL:      is_wmap = 1'b1;
            FN_WRITE_RUN, FN_GUARD_RUN: begin
                is_wmap = 1'b1;
                is_run  = 1'b1;
            end
            FN_READ:                    is_read = 1'b1;
            FN_GUARD_BIT:               is_wgrd = 1'b1;
            FN_NEXT_ONE, FN_PREV_ONE, FN_NEXT_ZERO, FN_PREV_ZERO: begin
                is_search = 1'b1;
            end
            default: ;
        endcase
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept && !d_err) begin
                    n_state = S_RUN;
                end
            end
            S_RUN: begin
                if (finish) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        busy   = 1'b1;
        run_on = 1'b0;
        unique case (r_state)
            S_IDLE:  busy = 1'b0;
            S_RUN:   run_on = 1'b1;
            default: busy = 1'b1;
        endcase
    end

    assign rd_en = run_on && r_rd_more;
    assign pv    = run_on && r_pv;

    // word unit: range mask, merge, change count and hit search
    assign map_w = r_map_vq ? r_map_q : '0;
    assign grd_w = r_grd_vq ? r_grd_q : '0;

    always_comb begin
        logic [IDX_W-1:0] g;
        for (int j = 0; j < WORD_BITS; j++) begin
            g      = {r_paddr, LB'(j)};
            inr[j] = (g >= r_lo) && ({1'b0, g} < r_hix);
        end
    end

    assign base_w = (r_func == FN_GUARD_BIT) ? grd_w : map_w;
    assign wmask  = inr & ((r_func == FN_GUARD_RUN) ? grd_w : '1);

    always_comb begin
        if (r_func == FN_FILL) begin
            new_word = {WORD_BITS{r_val}} & inr;
        end else begin
            new_word = (base_w & ~wmask) | ({WORD_BITS{r_val}} & wmask);
        end
    end

    always_comb begin
        logic [WORD_BITS-1:0] chg_bits;
        chg_bits = (map_w ^ {WORD_BITS{r_val}}) & wmask;
        pc = '0;
        for (int j = 0; j < WORD_BITS; j++) begin
            pc = pc + PC_W'(chg_bits[j]);
        end
    end

    // searched value: one for the set-bit scans, zero otherwise
    always_comb begin
        logic tgt;
        tgt   = (r_func == FN_NEXT_ONE) || (r_func == FN_PREV_ONE);
        match = ~(map_w ^ {WORD_BITS{tgt}}) & inr;
    end

    assign any_hit = |match;

    always_comb begin
        lo_pos = '0;
        for (int j = WORD_BITS - 1; j >= 0; j--) begin
            if (match[j]) lo_pos = LB'(j);
        end
    end

    always_comb begin
        hi_pos = '0;
        for (int j = 0; j < WORD_BITS; j++) begin
            if (match[j]) hi_pos = LB'(j);
        end
    end

    assign finish  = pv && (r_plast || (is_search && any_hit));
    assign map_we  = pv && is_wmap;
    assign grd_we  = pv && is_wgrd;
    assign cnt_sum = r_cnt + LEN_W'(pc);

    // state and configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_len   <= LEN_W'(MAP_BITS);
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_len <= i_cfg_wdata;
            end
        end
    end

    // request operands
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_func <= i_func;
            r_val  <= i_bit_value;
            r_lo   <= d_lo;
            r_hix  <= d_hix;
            r_last <= d_last;
            r_down <= d_down;
        end
    end

    // read pipeline control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_more <= 1'b0;
            r_pv      <= 1'b0;
            r_plast   <= 1'b0;
            r_rd_addr <= '0;
            r_paddr   <= '0;
            r_cnt     <= '0;
        end else if (accept && !d_err) begin
            r_rd_more <= 1'b1;
            r_pv      <= 1'b0;
            r_rd_addr <= d_first;
            r_cnt     <= '0;
        end else if (run_on) begin
            if (finish) begin
                r_rd_more <= 1'b0;
                r_pv      <= 1'b0;
            end else begin
                r_pv    <= r_rd_more;
                r_paddr <= r_rd_addr;
                r_plast <= (r_rd_addr == r_last);
                if (pv) begin
                    r_cnt <= cnt_sum;
                end
                if (r_rd_more) begin
                    r_rd_addr <= r_down ? (r_rd_addr - AW'(1)) : (r_rd_addr + AW'(1));
                    r_rd_more <= (r_rd_addr != r_last);
                end
            end
        end
    end

    // word memories
    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_map_q <= r_map_mem[r_rd_addr];
            r_grd_q <= r_grd_mem[r_rd_addr];
        end
        if (map_we) begin
            r_map_mem[r_paddr] <= new_word;
        end
        if (grd_we) begin
            r_grd_mem[r_paddr] <= new_word;
        end
    end

    // valid flags: an unwritten word reads as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_map_ok <= '0;
            r_grd_ok <= '0;
            r_map_vq <= 1'b0;
            r_grd_vq <= 1'b0;
        end else begin
            if (rd_en) begin
                r_map_vq <= r_map_ok[r_rd_addr];
                r_grd_vq <= r_grd_ok[r_rd_addr];
            end
            if (map_we) begin
                r_map_ok[r_paddr] <= 1'b1;
            end
            if (grd_we) begin
                r_grd_ok[r_paddr] <= 1'b1;
            end
        end
    end

    // result strobe and fields
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= (accept && d_err) || finish;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && d_err) begin
            r_status <= 1'b1;
            r_found  <= '0;
            r_rbit   <= 1'b0;
            r_chg    <= '0;
        end else if (finish) begin
            r_status <= is_search && !any_hit;
            r_found  <= (is_search && any_hit) ?
                        {r_paddr, (r_down ? hi_pos : lo_pos)} : '0;
            r_rbit   <= is_read && map_w[r_lo[LB-1:0]];
            r_chg    <= is_run ? cnt_sum : '0;
        end
    end

    assign o_done          = r_done;
    assign o_status        = r_status;
    assign o_found_index   = r_found;
    assign o_read_bit      = r_rbit;
    assign o_changed_count = r_chg;

`ifndef ASSERT_OFF
    // a result never shows while a walk is still running
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("result strobe while busy");

    // an accepted request in range starts a walk and gives no result at once
    a_walk_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && !d_err) |=> (busy && !o_done))
        else $error("valid request did not start a walk");

    // no memory reads are issued outside a walk
    a_reads_in_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rd_more |-> (r_state == S_RUN))
        else $error("read pending outside a walk");

    // a rejected request answers on the next cycle with an error
    a_reject: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && d_err) |=> (o_done && o_status && !busy))
        else $error("rejected request not answered");
`endif

endmodule

`default_nettype wire
